// File: hdl/sc1kd_pkg.sv
// ----------------------------------------------------------------------------
// sc1kd_pkg
// Scancode set 1 constants, result layout and the key to character table.
// ----------------------------------------------------------------------------
package sc1kd_pkg;

  localparam int unsigned ScanW     = 8;
  localparam int unsigned CodeW     = 7;
  localparam int unsigned CharW     = 7;
  localparam int unsigned ModW      = 4;
  localparam int unsigned ResultW   = 1 + CodeW + CharW + ModW;
  localparam int unsigned OutDataW  = ((ResultW + 7) / 8) * 8;

  localparam logic [ScanW-1:0] PrefixByte = 8'hE0;
  localparam int unsigned      ReleaseBit = 7;

  localparam logic [CodeW-1:0] ScLShift = 7'h2A;
  localparam logic [CodeW-1:0] ScRShift = 7'h36;
  localparam logic [CodeW-1:0] ScCtrl   = 7'h1D;
  localparam logic [CodeW-1:0] ScAlt    = 7'h38;
  localparam logic [CodeW-1:0] ScLSuper = 7'h5B;
  localparam logic [CodeW-1:0] ScRSuper = 7'h5C;

  localparam logic [CharW-1:0] CaseOffset = 7'd32;

  typedef struct packed {
    logic             super_held;
    logic             alt_held;
    logic             ctrl_held;
    logic             shift_held;
  } mod_flags_t;

  typedef struct packed {
    logic [ModW-1:0]  modifier_mask;
    logic [CharW-1:0] ascii_char;
    logic [CodeW-1:0] key_code;
    logic             key_up;
  } key_report_t;

  function automatic logic [CharW-1:0] map_char(input logic [CodeW-1:0] code,
                                                input logic shifted);
    logic [CharW-1:0] c;
    logic             letter;
    letter = 1'b1;
    unique case (code)
      7'h02:   c = 7'h31;
      7'h03:   c = 7'h32;
      7'h04:   c = 7'h33;
      7'h05:   c = 7'h34;
      7'h06:   c = 7'h35;
      7'h07:   c = 7'h36;
      7'h08:   c = 7'h37;
      7'h09:   c = 7'h38;
      7'h0A:   c = 7'h39;
      7'h0B:   c = 7'h30;
      7'h10:   c = 7'h71;
      7'h11:   c = 7'h77;
      7'h12:   c = 7'h65;
      7'h13:   c = 7'h72;
      7'h14:   c = 7'h74;
      7'h15:   c = 7'h79;
      7'h16:   c = 7'h75;
      7'h17:   c = 7'h69;
      7'h18:   c = 7'h6F;
      7'h19:   c = 7'h70;
      7'h1E:   c = 7'h61;
      7'h1F:   c = 7'h73;
      7'h20:   c = 7'h64;
      7'h21:   c = 7'h66;
      7'h22:   c = 7'h67;
      7'h23:   c = 7'h68;
      7'h24:   c = 7'h6A;
      7'h25:   c = 7'h6B;
      7'h26:   c = 7'h6C;
      7'h2C:   c = 7'h7A;
      7'h2D:   c = 7'h78;
      7'h2E:   c = 7'h63;
      7'h2F:   c = 7'h76;
      7'h30:   c = 7'h62;
      7'h31:   c = 7'h6E;
      7'h32:   c = 7'h6D;
      7'h39:   c = 7'h20;
      default: c = '0;
    endcase
    if (c < 7'h61 || c > 7'h7A) begin
      letter = 1'b0;
    end
    if (shifted && letter) begin
      c = c - CaseOffset;
    end
    return c;
  endfunction

endpackage

// File: hdl/scancode_set1_key_decoder.sv
// Takes one set 1 scancode byte per transfer and returns at most one key
// event per byte, in order. A byte can be taken every cycle unless a byte sits
// in the input register while a result waits unaccepted: it is captured in
// that input register and decoded by a small lookup between it and the result
// register. The 0xE0 prefix and the shift, ctrl, alt and super keys give no
// event; the modifier keys update latched flags that form the mask of later
// events. The output register lets the next byte enter while a result waits.
// ----------------------------------------------------------------------------
// scancode_set1_key_decoder
// Set 1 scancode to key event decoder with latched modifier flags.
// ----------------------------------------------------------------------------
module scancode_set1_key_decoder (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                s_axis_tvalid_i,
  output logic                                s_axis_tready_o,
  // [7:0] scan_byte
  input  logic [sc1kd_pkg::ScanW-1:0]         s_axis_tdata_i,
  output logic                                m_axis_tvalid_o,
  input  logic                                m_axis_tready_i,
  // [0] key_up, [7:1] key_code, [14:8] ascii_char, [18:15] modifier_mask
  output logic [sc1kd_pkg::OutDataW-1:0]      m_axis_tdata_o
);

  logic                              in_valid_q;
  logic [sc1kd_pkg::ScanW-1:0]       in_byte_q;
  sc1kd_pkg::mod_flags_t             flags_q, flags_d;
  logic                              out_valid_q, out_valid_d;
  sc1kd_pkg::key_report_t            out_evt_q, evt_d;

  logic                              advance;
  logic                              is_prefix;
  logic                              up;
  logic [sc1kd_pkg::CodeW-1:0]       code;
  logic                              is_mod;

  assign advance         = in_valid_q && (!out_valid_q || m_axis_tready_i);
  assign s_axis_tready_o = !in_valid_q || advance;

  assign is_prefix = (in_byte_q == sc1kd_pkg::PrefixByte);
  assign up        = in_byte_q[sc1kd_pkg::ReleaseBit];
  assign code      = in_byte_q[sc1kd_pkg::CodeW-1:0];

  always_comb begin
    flags_d = flags_q;
    is_mod  = 1'b0;
    if (!is_prefix) begin
      unique case (code)
        sc1kd_pkg::ScLShift, sc1kd_pkg::ScRShift: begin
          flags_d.shift_held = !up;
          is_mod             = 1'b1;
        end
        sc1kd_pkg::ScCtrl: begin
          flags_d.ctrl_held = !up;
          is_mod            = 1'b1;
        end
        sc1kd_pkg::ScAlt: begin
          flags_d.alt_held = !up;
          is_mod           = 1'b1;
        end
        sc1kd_pkg::ScLSuper, sc1kd_pkg::ScRSuper: begin
          flags_d.super_held = !up;
          is_mod             = 1'b1;
        end
        default: begin
          is_mod = 1'b0;
        end
      endcase
    end
  end

  always_comb begin
    evt_d.key_up        = up;
    evt_d.key_code      = code;
    evt_d.ascii_char    = sc1kd_pkg::map_char(code, flags_q.shift_held);
    evt_d.modifier_mask = flags_q;
  end

  always_comb begin
    out_valid_d = out_valid_q && !m_axis_tready_i;
    if (advance && !is_prefix && !is_mod) begin
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      flags_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (s_axis_tready_o) begin
        in_valid_q <= s_axis_tvalid_i;
      end
      if (advance) begin
        flags_q <= flags_d;
      end
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready_o && s_axis_tvalid_i) begin
      in_byte_q <= s_axis_tdata_i;
    end
    if (advance && !is_prefix && !is_mod) begin
      out_evt_q <= evt_d;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {{(sc1kd_pkg::OutDataW - sc1kd_pkg::ResultW){1'b0}}, out_evt_q};

endmodule
